/* src/rlfg_pkg.sv */
package rlfg_pkg;

   localparam int PHASE_W        = 27;
   localparam int LED_COUNT_W    = 7;
   localparam int PIX_W          = 6;
   localparam int COLOR_W        = 8;
   localparam int LED_LIMIT_DFLT = 64;

   localparam int WHEEL_STEPS    = 1536;
   localparam int FRAME_DIVISOR  = 360;
   localparam logic [PHASE_W-1:0] WHEEL_RANGE = PHASE_W'(WHEEL_STEPS * 65536);
   localparam logic [PHASE_W-1:0] BASE_STEP   =
      PHASE_W'((WHEEL_STEPS * 65536) / FRAME_DIVISOR);

   localparam logic [COLOR_W-1:0] FULL = 8'hFF;

   typedef logic [PHASE_W-1:0] phase_type;

   typedef struct packed {
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } rgb_type;

   // advance on the wheel, wrap at the range (step never exceeds it)
   function automatic phase_type phase_add(phase_type a, phase_type b);
      logic [PHASE_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      if (sum >= {1'b0, WHEEL_RANGE}) begin
         sum = sum - {1'b0, WHEEL_RANGE};
      end
      return sum[PHASE_W-1:0];
   endfunction

   function automatic rgb_type wheel_color(phase_type phase);
      logic [2:0]         seg;
      logic [COLOR_W-1:0] off;
      rgb_type            c;
      seg = phase[PHASE_W-1:PHASE_W-3];
      off = phase[PHASE_W-4:PHASE_W-11];
      unique case (seg)
         3'd0: begin
            c = '{red: FULL, green: off, blue: '0};
         end
         3'd1: begin
            c = '{red: FULL - off, green: FULL, blue: '0};
         end
         3'd2: begin
            c = '{red: '0, green: FULL, blue: off};
         end
         3'd3: begin
            c = '{red: '0, green: FULL - off, blue: FULL};
         end
         3'd4: begin
            c = '{red: off, green: '0, blue: FULL};
         end
         default: begin
            c = '{red: FULL, green: '0, blue: FULL - off};
         end
      endcase
      return c;
   endfunction

endpackage

/* src/rlfg_req_if.sv */
interface rlfg_req_if;
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink   (input valid, input restart, output ready);
endinterface

/* src/rlfg_rsp_if.sv */
interface rlfg_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [rlfg_pkg::PIX_W-1:0]     pixel_index;
   logic [rlfg_pkg::COLOR_W-1:0]   red;
   logic [rlfg_pkg::COLOR_W-1:0]   green;
   logic [rlfg_pkg::COLOR_W-1:0]   blue;
   logic                           last_pixel;

   modport source (output valid, output pixel_index, output red, output green,
                   output blue, output last_pixel, input ready);
   modport sink   (input valid, input pixel_index, input red, input green,
                   input blue, input last_pixel, output ready);
endinterface

/* src/rainbow_led_frame_generator.sv */
// channel   dir  handshake     payload
// req_chan  in   valid/ready   restart
// rsp_chan  out  valid/ready   pixel_index, red, green, blue, last_pixel
// csr       in   csr_wr_en     csr_wr_data (led_count)
//
// A frame tick is accepted in idle, runs the bit-serial divider (wheel
// range / LED count), then emits one pixel per cycle while rsp is not stalled.
// Output register decouples emission; rsp stalls hold the pixel sequencer.
// Synchronous active-high reset: led_count = 1, base phase = 0, idle.
module rainbow_led_frame_generator #(
   parameter int LED_LIMIT = rlfg_pkg::LED_LIMIT_DFLT
) (
   input  logic                              clock,
   input  logic                              reset,
   rlfg_req_if.sink                          req_chan,
   rlfg_rsp_if.source                        rsp_chan,
   input  logic                              csr_wr_en,
   input  logic [rlfg_pkg::LED_COUNT_W-1:0]  csr_wr_data
);

   localparam int CNT_W     = $clog2(LED_LIMIT + 1);
   localparam int DIV_CNT_W = $clog2(rlfg_pkg::PHASE_W);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0]                            state_ff, state_in;
   logic [rlfg_pkg::LED_COUNT_W-1:0]      led_count_ff, led_count_in;
   rlfg_pkg::phase_type                   base_ff, base_in;
   rlfg_pkg::phase_type                   phase_ff, phase_in;
   rlfg_pkg::phase_type                   quo_ff, quo_in;
   logic [CNT_W-1:0]                      rem_ff, rem_in;
   logic [CNT_W-1:0]                      n_ff, n_in;
   logic [CNT_W-1:0]                      idx_ff, idx_in;
   logic [DIV_CNT_W-1:0]                  bit_ff, bit_in;

   logic                                  rsp_valid_ff, rsp_valid_in;
   logic [rlfg_pkg::PIX_W-1:0]            pix_ff, pix_in;
   rlfg_pkg::rgb_type                     rgb_ff, rgb_in;
   logic                                  last_ff, last_in;

   logic                                  req_fire;
   logic                                  load;
   logic                                  is_last;
   logic [CNT_W:0]                        trial;
   logic                                  qbit;
   logic [CNT_W-1:0]                      n_sat;
   rlfg_pkg::phase_type                   start;

   assign req_chan.ready   = (state_ff == ST_IDLE);
   assign req_fire         = req_chan.valid && req_chan.ready;
   assign load             = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_chan.ready);
   assign is_last          = ((idx_ff + CNT_W'(1)) == n_ff);
   assign trial            = {rem_ff, rlfg_pkg::WHEEL_RANGE[bit_ff]};
   assign qbit             = (trial >= {1'b0, n_ff});
   assign start            = req_chan.restart ? '0 : base_ff;

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.pixel_index = pix_ff;
   assign rsp_chan.red         = rgb_ff.red;
   assign rsp_chan.green       = rgb_ff.green;
   assign rsp_chan.blue        = rgb_ff.blue;
   assign rsp_chan.last_pixel  = last_ff;

   always_comb begin
      priority if (led_count_ff == '0) begin
         n_sat = CNT_W'(1);
      end else if (32'(led_count_ff) > 32'(LED_LIMIT)) begin
         n_sat = CNT_W'(LED_LIMIT);
      end else begin
         n_sat = CNT_W'(led_count_ff);
      end
   end

   always_comb begin
      state_in     = state_ff;
      led_count_in = csr_wr_en ? csr_wr_data : led_count_ff;
      base_in      = base_ff;
      phase_in     = phase_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      n_in         = n_ff;
      idx_in       = idx_ff;
      bit_in       = bit_ff;
      rsp_valid_in = rsp_valid_ff;
      pix_in       = pix_ff;
      rgb_in       = rgb_ff;
      last_in      = last_ff;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               n_in     = n_sat;
               phase_in = start;
               base_in  = rlfg_pkg::phase_add(start, rlfg_pkg::BASE_STEP);
               rem_in   = '0;
               bit_in   = DIV_CNT_W'(rlfg_pkg::PHASE_W - 1);
               idx_in   = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            // restoring divide, one quotient bit per cycle
            rem_in = qbit ? CNT_W'(trial - {1'b0, n_ff}) : trial[CNT_W-1:0];
            quo_in = {quo_ff[rlfg_pkg::PHASE_W-2:0], qbit};
            bit_in = bit_ff - DIV_CNT_W'(1);
            if (bit_ff == '0) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (load) begin
               rsp_valid_in = 1'b1;
               pix_in       = rlfg_pkg::PIX_W'(idx_ff);
               rgb_in       = rlfg_pkg::wheel_color(phase_ff);
               last_in      = is_last;
               phase_in     = rlfg_pkg::phase_add(phase_ff, quo_ff);
               idx_in       = idx_ff + CNT_W'(1);
               if (is_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         led_count_ff <= rlfg_pkg::LED_COUNT_W'(1);
         base_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         led_count_ff <= led_count_in;
         base_ff      <= base_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      phase_ff <= phase_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      n_ff     <= n_in;
      idx_ff   <= idx_in;
      bit_ff   <= bit_in;
      pix_ff   <= pix_in;
      rgb_ff   <= rgb_in;
      last_ff  <= last_in;
   end

endmodule
